FILE: hw/rtl/wsdf_pkg.sv
// ---------------------------------------------------------------------------
// wsdf_pkg: shared types and constants for the WebSocket deframer/unmasker
// Result kinds, error codes, opcodes and the request passed front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

  localparam int WSDF_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NO_MASK  = 3'd0;
  localparam logic [2:0] ERR_EXT_LEN  = 3'd1;
  localparam logic [2:0] ERR_CONT_TXT = 3'd2;
  localparam logic [2:0] ERR_PING     = 3'd3;
  localparam logic [2:0] ERR_PONG     = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // last header byte index (flags, length, four key bytes)
  localparam logic [2:0] HDR_LAST = 3'd5;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;   // received byte, zero for close/error
    logic [7:0] key;    // key byte to apply, zero for close/error
    logic       last;
    logic [2:0] code;
  } req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer_unmask.sv
// Path: a byte enters the request queue, then is unmasked into the output register.
// Throughput: one byte per cycle while out_tready stays high; the queue plus output
// register absorb downstream stalls, and in_tready drops only when the queue is full.
// Reset: synchronous, active low; clears parser phase, counters and queue
// state. The masking key is not reset and is always written before use.
// ---------------------------------------------------------------------------
// websocket_frame_deframer_unmask: WebSocket client frame parser/unmasker
// Header check front end, request queue and unmask/output back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unmask
  import wsdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = WSDF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] payload_byte, [10:8] error_code, rest 0
  output logic             out_tlast,  // last_of_frame
  output logic [1:0]       out_tuser   // [1:0] kind
);

  logic push, q_ready, pop, rd_valid;
  req_t wr_req, rd_req;

  wsdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .q_ready   (q_ready),
    .push      (push),
    .req       (wr_req)
  );

  wsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_req   (wr_req),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_req   (rd_req),
    .rd_valid (rd_valid)
  );

  wsdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_req     (rd_req),
    .rd_valid   (rd_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/wsdf_front.sv
// ---------------------------------------------------------------------------
// wsdf_front: header parser and frame tracker
// Takes one byte per request, collects the six-byte header, checks it and
// queues one request per payload byte, close or error.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsdf_front
  import wsdf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_ready,
  output logic            push,
  output req_t            req
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CLOSED  = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] hcnt_r, hcnt_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [7:0] mlen_r, mlen_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic [1:0] kpos_r, kpos_nxt;
  logic [7:0] key_r [4];

  logic       acc;
  logic       key_we;
  logic [1:0] key_idx;
  logic       err_hit;
  logic [2:0] err_code;
  logic [6:0] len;
  logic [3:0] opc;

  assign in_tready = q_ready;
  assign acc       = in_tvalid & q_ready;
  assign key_idx   = hcnt_r[1:0] - 2'd2;
  assign len       = mlen_r[6:0];
  assign opc       = flags_r[3:0];
  assign key_we    = acc && (phase_r == PH_HEADER) && (hcnt_r >= 3'd2);

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    flags_nxt = flags_r;
    mlen_nxt  = mlen_r;
    rem_nxt   = rem_r;
    kpos_nxt  = kpos_r;
    push      = 1'b0;
    req       = '0;
    err_hit   = 1'b0;
    err_code  = ERR_NO_MASK;
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hcnt_r == 3'd0) begin
            flags_nxt = in_byte;
          end else if (hcnt_r == 3'd1) begin
            mlen_nxt = in_byte;
          end
          if (hcnt_r == HDR_LAST) begin
            hcnt_nxt = 3'd0;
            if (!mlen_r[7]) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_MASK;
            end else if (len == LEN_EXT16 || len == LEN_EXT64) begin
              err_hit  = 1'b1;
              err_code = ERR_EXT_LEN;
            end else begin
              unique case (opc) inside
                OPC_CONT, OPC_TEXT: begin
                  err_hit  = 1'b1;
                  err_code = ERR_CONT_TXT;
                end
                OPC_BIN: begin
                  kpos_nxt  = 2'd0;
                  rem_nxt   = len;
                  phase_nxt = (len != 7'd0) ? PH_PAYLOAD : PH_HEADER;
                end
                OPC_CLOSE: begin
                  phase_nxt = PH_CLOSED;
                  push      = 1'b1;
                  req.kind  = KIND_CLOSE;
                end
                OPC_PING: begin
                  err_hit  = 1'b1;
                  err_code = ERR_PING;
                end
                OPC_PONG: begin
                  err_hit  = 1'b1;
                  err_code = ERR_PONG;
                end
                default: begin
                  err_hit  = 1'b1;
                  err_code = ERR_UNKNOWN;
                end
              endcase
            end
            if (err_hit) begin
              phase_nxt = PH_ERROR;
              push      = 1'b1;
              req.kind  = KIND_ERROR;
              req.code  = err_code;
            end
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt  = rem_r - 7'd1;
          kpos_nxt = kpos_r + 2'd1;
          push     = 1'b1;
          req.kind = KIND_DATA;
          req.data = in_byte;
          req.key  = key_r[kpos_r];
          req.last = (rem_nxt == 7'd0);
          if (rem_nxt == 7'd0) begin
            phase_nxt = PH_HEADER;
            hcnt_nxt  = 3'd0;
            kpos_nxt  = 2'd0;
          end
        end
        PH_CLOSED, PH_ERROR: begin
          // sticky: bytes are taken and dropped
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 3'd0;
      flags_r <= 8'd0;
      mlen_r  <= 8'd0;
      rem_r   <= 7'd0;
      kpos_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      flags_r <= flags_nxt;
      mlen_r  <= mlen_nxt;
      rem_r   <= rem_nxt;
      kpos_r  <= kpos_nxt;
    end
  end

  // masking key, written only during header collection
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r[key_idx] <= in_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_sticky_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLOSED || phase_r == PH_ERROR) |-> !push)
    else $error("request queued after close or error");

  a_hdr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER && hcnt_r != HDR_LAST) |-> !push)
    else $error("request queued mid-header");

  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HDR_LAST)
    else $error("header count out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/wsdf_queue.sv
// ---------------------------------------------------------------------------
// wsdf_queue: short request queue between parser and output stage
// Register-based FIFO; ready depends only on the fill count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsdf_queue
  import wsdf_pkg::*;
#(
  parameter int DEPTH = WSDF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      wr_req,
  output logic      wr_ready,
  input  wire logic pop,
  output req_t      rd_req,
  output logic      rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_req   = mem_r[rd_ptr_r];
  assign do_push  = push & wr_ready;
  assign do_pop   = pop & rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_req;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/wsdf_back.sv
// ---------------------------------------------------------------------------
// wsdf_back: unmask and output register
// Pops a queued request, applies the key byte and holds the result until
// the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsdf_back
  import wsdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  req_t             rd_req,
  input  wire logic        rd_valid,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);

  logic       vld_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [2:0] code_r;

  assign pop        = rd_valid & (!vld_r | out_tready);
  assign out_tvalid = vld_r;
  assign out_tdata  = {5'd0, code_r, byte_r};
  assign out_tlast  = last_r;
  assign out_tuser  = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= rd_req.kind;
      byte_r <= rd_req.data ^ rd_req.key;
      last_r <= rd_req.last;
      code_r <= rd_req.code;
    end
  end

`ifndef NO_ASSERTIONS
  a_ctrl_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && kind_r != KIND_DATA) |-> (!last_r && byte_r == 8'd0))
    else $error("close/error result with payload or last set");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: WebSocket deframer/unmasker check
// Drives masked client frames one byte per request. A scoreboard predicts each
// unmasked payload byte, close or error result, and compares it with the
// output stream. Both sides idle at random, and the receiver stalls once for
// a long stretch. Every run ends with a close or with one rejected header,
// after which the block stays silent.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import wsdf_pkg::*;

typedef enum logic [1:0] {
  PH_HEADER  = 2'd0,
  PH_PAYLOAD = 2'd1,
  PH_CLOSED  = 2'd2,
  PH_ERROR   = 2'd3
} deframe_phase_t;

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] payload;
  logic       last;
  logic [2:0] code;
} deframe_result_t;

localparam logic [2:0] NO_CODE = 3'd0;

class deframe_scoreboard;
  deframe_phase_t  phase;
  logic [2:0]      hdr_cnt;
  logic [7:0]      flags_op;
  logic [7:0]      mask_len;
  logic [7:0]      key [4];
  logic [6:0]      left;
  logic [1:0]      kpos;
  deframe_result_t pending [$];
  int              errors;
  int              frames_seen;
  int              payload_out;

  function new();
    phase = PH_HEADER;
    hdr_cnt = 3'd0;
    flags_op = 8'h00;
    mask_len = 8'h00;
    foreach (key[i]) key[i] = 8'h00;
    left = 7'd0;
    kpos = 2'd0;
    errors = 0;
    frames_seen = 0;
    payload_out = 0;
  endfunction

  function void push(logic [1:0] kind, logic [7:0] payload, logic last, logic [2:0] code);
    deframe_result_t r;
    r.kind = kind;
    r.payload = payload;
    r.last = last;
    r.code = code;
    pending.push_back(r);
  endfunction

  function void reject(logic [2:0] code);
    phase = PH_ERROR;
    push(KIND_ERROR, 8'h00, 1'b0, code);
  endfunction

  // advance the predicted parser by one accepted byte
  function void take_byte(logic [7:0] b);
    logic [2:0] idx;
    logic [6:0] len;
    idx = hdr_cnt - 3'd2;
    case (phase)
      PH_HEADER: begin
        if (hdr_cnt == 3'd0) flags_op = b;
        else if (hdr_cnt == 3'd1) mask_len = b;
        else key[idx[1:0]] = b;
        if (hdr_cnt != HDR_LAST) begin
          hdr_cnt = hdr_cnt + 3'd1;
        end else begin
          hdr_cnt = 3'd0;
          len = mask_len[6:0];
          // mask bit first, then length form, then opcode
          if (!mask_len[7]) begin
            reject(ERR_NO_MASK);
          end else if (len == LEN_EXT16 || len == LEN_EXT64) begin
            reject(ERR_EXT_LEN);
          end else begin
            case (flags_op[3:0])
              OPC_CONT, OPC_TEXT: reject(ERR_CONT_TXT);
              OPC_PING: reject(ERR_PING);
              OPC_PONG: reject(ERR_PONG);
              OPC_CLOSE: begin
                phase = PH_CLOSED;
                push(KIND_CLOSE, 8'h00, 1'b0, NO_CODE);
              end
              OPC_BIN: begin
                frames_seen++;
                kpos = 2'd0;
                left = len;
                phase = (len != 7'd0) ? PH_PAYLOAD : PH_HEADER;
              end
              default: reject(ERR_UNKNOWN);
            endcase
          end
        end
      end
      PH_PAYLOAD: begin
        left = left - 7'd1;
        push(KIND_DATA, b ^ key[kpos], left == 7'd0, NO_CODE);
        kpos = kpos + 2'd1;
        if (left == 7'd0) begin
          phase = PH_HEADER;
          hdr_cnt = 3'd0;
          kpos = 2'd0;
        end
      end
      default: ;  // closed or failed: bytes are swallowed
    endcase
  endfunction

  function void check_result(logic [1:0] kind, logic [7:0] payload, logic last,
                             logic [2:0] code, logic [4:0] spare);
    deframe_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result: kind %0d payload %02h code %0d", kind, payload, code);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (kind === KIND_DATA) payload_out++;
    if (kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, kind);
      errors++;
    end
    if (payload !== e.payload) begin
      $error("payload_byte: expected %02h, got %02h", e.payload, payload);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_of_frame: expected %0d, got %0d", e.last, last);
      errors++;
    end
    if (code !== e.code) begin
      $error("error_code: expected %0d, got %0d", e.code, code);
      errors++;
    end
    if (spare !== 5'd0) begin
      $error("tdata_pad: expected 0, got %02h", spare);
      errors++;
    end
  endfunction
endclass

module testbench;

  typedef enum int {
    END_CLOSE, END_NO_MASK, END_EXT_LEN, END_CONT_TXT, END_PING, END_PONG, END_UNKNOWN
  } ending_t;

  localparam int STREAM_TARGET  = 1040;  // bytes of random frames, headers included
  localparam int HOLD_AT        = 600;   // requests taken before the long stall
  localparam int HOLD_CYCLES    = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  deframe_scoreboard sb = new();

  int      bytes_in = 0;
  int      in_stall_cycles = 0;
  bit      tx_burst;
  ending_t ending;

  websocket_frame_deframer_unmask DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.take_byte(in_tdata);
      bytes_in <= bytes_in + 1;
    end
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles <= in_stall_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata[7:0], out_tlast, out_tdata[10:8],
                      out_tdata[15:11]);
    end
  end

  // receiver: random stalls in stretches, plus one long hold-off
  initial begin : rx_side
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    int unsigned stall_pct;
    int unsigned cyc;
    bit          hold_done;
    stall_cnt = 0;
    hold_cnt = 0;
    stall_pct = 0;
    cyc = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      cyc++;
      if (!hold_done && bytes_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_cnt = gap_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned g;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = (tx_burst || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_header(input logic [7:0] flags, input logic [7:0] mlen,
                             input logic [31:0] mkey);
    send_byte(flags);
    send_byte(mlen);
    for (int i = 0; i < 4; i++) send_byte(mkey[8*i +: 8]);
  endtask

  // fill < 0 gives random payload bytes
  task automatic send_binary(input logic [3:0] hi, input logic [6:0] len,
                             input logic [31:0] mkey, input int fill);
    tx_burst = ($urandom_range(0, 4) == 0);
    send_header({hi, OPC_BIN}, {1'b1, len}, mkey);
    for (int i = 0; i < len; i++) begin
      send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
  endtask

  // the run ends with a close or with one rejected header
  task automatic send_ending();
    logic [3:0] opc;
    logic [6:0] len;
    int unsigned u;
    ending = ending_t'($urandom_range(0, 6));
    len = 7'($urandom_range(0, 125));
    case (ending)
      END_CLOSE:    opc = OPC_CLOSE;
      END_CONT_TXT: opc = $urandom_range(0, 1) ? OPC_TEXT : OPC_CONT;
      END_PING:     opc = OPC_PING;
      END_PONG:     opc = OPC_PONG;
      END_UNKNOWN: begin
        u = $urandom_range(3, 12);
        opc = 4'(u > 7 ? u + 3 : u);
      end
      default:      opc = 4'($urandom_range(0, 15));
    endcase
    case (ending)
      END_NO_MASK: send_header({4'($urandom_range(0, 15)), opc}, {1'b0, 7'($urandom_range(0, 127))},
                               $urandom());
      END_EXT_LEN: send_header({4'($urandom_range(0, 15)), opc},
                               {1'b1, $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64}, $urandom());
      default:     send_header({4'($urandom_range(0, 15)), opc}, {1'b1, len}, $urandom());
    endcase
    // whatever follows is swallowed
    repeat (int'(len) + 16) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int stream_sent;
    int unsigned r;
    int unsigned len;
    stream_sent = 0;
    tx_burst = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: key and payload extremes, flag bits, zero length, key wrap, max length
    send_binary(4'h8, 7'd1, 32'h0000_0000, 8'hFF);
    send_binary(4'h0, 7'd0, $urandom(), -1);
    send_binary(4'h7, 7'd4, 32'hFFFF_FFFF, 8'h00);
    send_binary(4'hF, 7'd5, $urandom(), -1);
    send_binary(4'h8, 7'd125, $urandom(), -1);
    send_binary(4'h8, 7'd0, 32'hFFFF_FFFF, -1);
    send_binary(4'h0, 7'd2, 32'h0000_0000, 8'h00);

    // random well-formed binary frames, mostly short
    while (stream_sent < STREAM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(0, 8);
      else if (r < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(100, 125);
      send_binary(4'($urandom_range(0, 15)), 7'(len), $urandom(), -1);
      stream_sent += int'(len) + 6;
    end

    tx_burst = 1'b0;
    send_ending();
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d bytes in, %0d binary frames, %0d payload bytes out",
             bytes_in, sb.frames_seen, sb.payload_out);
    $display("summary: input stalled %0d cycles, run ended by %s",
             in_stall_cycles, ending.name());
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/wsdf_pkg.sv
hw/rtl/wsdf_front.sv
hw/rtl/wsdf_queue.sv
hw/rtl/wsdf_back.sv
hw/rtl/websocket_frame_deframer_unmask.sv
tb/testbench.sv
